// ----- hdl/next_lexicographic_permutation_macros.svh -----
// assertion helpers used by next_lexicographic_permutation.sv
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_MACROS_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_MACROS_SVH

// same-cycle implication
`define NLP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nlp check failed");

// next-cycle implication
`define NLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nlp check failed");

`endif

// ----- hdl/nlp_pkg.sv -----
`default_nettype none

package nlp_pkg;

   localparam int MAX_SYMBOLS = 8;
   localparam int SYMBOL_BITS = 8;
   localparam int IDX_BITS    = $clog2(MAX_SYMBOLS);
   localparam int COUNT_BITS  = 4;
   localparam int WORD_BITS   = MAX_SYMBOLS * SYMBOL_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(MAX_SYMBOLS);

   typedef logic [SYMBOL_BITS-1:0] symbol_type;
   typedef symbol_type [MAX_SYMBOLS-1:0] sym_array_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic                 is_last;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/next_lexicographic_permutation.sv -----
// next lexicographic permutation of up to eight packed 8-bit symbols
//
// input channel req_*: one packed arrangement per transfer, position k in
// bits 8k+7:8k. result channel rsp_*: the next arrangement in the same
// packing with unused slots zero, and rsp_is_last set when the input had no
// ascent (input symbols returned unchanged).
// csr_wr_en / csr_wr_data set the symbol count (values above 8 act as 8,
// values below 2 always give is_last); write it only while the block is idle.
//
// the datapath is an input register, one combinational pass, and a result
// register: a req transfer is registered in the input register and then in
// the result register, which drives rsp_valid, and one item per cycle is
// sustained while rsp_ready stays high. the critical path is the ascent
// priority search followed by the ceiling compare and the reversing mux.
// a stalled receiver holds the result register; the input register still
// takes a transfer while it is empty, so req_ready drops only when both
// stages are full and rsp_ready is low.
// reset clears both valid flags and sets the symbol count to 8.

`default_nettype none

`include "next_lexicographic_permutation_macros.svh"

module next_lexicographic_permutation
   import nlp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [WORD_BITS-1:0]  req_arrangement,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [WORD_BITS-1:0]       rsp_next_arrangement,
   output logic                       rsp_is_last,
   input  wire logic                  csr_wr_en,
   input  wire logic [COUNT_BITS-1:0] csr_wr_data
);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [WORD_BITS-1:0]  in_word_ff;
   logic [WORD_BITS-1:0]  in_word_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   result_type            out_ff;
   result_type            out_in;
   result_type            core_result;
   logic                  advance;
   logic                  load;

   nlp_core u_core (
      .arrangement (in_word_ff),
      .count       (count_ff),
      .result      (core_result)
   );

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_in       = core_result;
      end
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (load) begin
         in_word_in = req_arrangement;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      out_ff     <= out_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_next_arrangement = out_ff.word;
   assign rsp_is_last          = out_ff.is_last;

   `NLP_ASSERT_NEXT(a_load_fills_input, clock, reset, load, in_valid_ff)
   `NLP_ASSERT_NEXT(a_advance_fills_output, clock, reset,
                    in_valid_ff && advance, out_valid_ff)
   `NLP_ASSERT_NEXT(a_stall_holds_input, clock, reset,
                    in_valid_ff && !advance, in_valid_ff && $stable(in_word_ff))
   `NLP_ASSERT_NOW(a_ready_when_output_free, clock, reset, !out_valid_ff, req_ready)

endmodule

`default_nettype wire

// ----- hdl/nlp_core.sv -----
`default_nettype none

module nlp_core
   import nlp_pkg::*;
(
   input  wire logic [WORD_BITS-1:0]  arrangement,
   input  wire logic [COUNT_BITS-1:0] count,
   output result_type                 result
);

   always_comb begin
      sym_array_type         sym;
      sym_array_type         swp;
      sym_array_type         nxt;
      logic [COUNT_BITS-1:0] n;
      logic [IDX_BITS-1:0]   pivot;
      logic [IDX_BITS-1:0]   ceil_pos;
      logic                  found;
      symbol_type            piv_sym;
      logic [IDX_BITS+1:0]   r;

      n = (count > COUNT_BITS'(MAX_SYMBOLS)) ? COUNT_BITS'(MAX_SYMBOLS) : count;

      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         sym[k] = arrangement[k*SYMBOL_BITS +: SYMBOL_BITS];
      end

      // rightmost ascent inside the used slots
      pivot = '0;
      found = 1'b0;
      for (int k = 0; k < MAX_SYMBOLS - 1; k++) begin
         if (COUNT_BITS'(k + 1) < n && sym[k] < sym[k+1]) begin
            pivot = IDX_BITS'(k);
            found = 1'b1;
         end
      end
      piv_sym = sym[pivot];

      // suffix is non-increasing, so the rightmost greater symbol is the ceiling
      ceil_pos = '0;
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         if (IDX_BITS'(j) > pivot && COUNT_BITS'(j) < n && sym[j] > piv_sym) begin
            ceil_pos = IDX_BITS'(j);
         end
      end

      swp           = sym;
      swp[pivot]    = sym[ceil_pos];
      swp[ceil_pos] = piv_sym;

      // after the swap the suffix is still descending: reverse it
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         r = (IDX_BITS+2)'(pivot) + (IDX_BITS+2)'(n) - (IDX_BITS+2)'(k);
         if (COUNT_BITS'(k) >= n) begin
            nxt[k] = '0;
         end else if (!found) begin
            nxt[k] = sym[k];
         end else if (IDX_BITS'(k) <= pivot) begin
            nxt[k] = swp[k];
         end else begin
            nxt[k] = swp[r[IDX_BITS-1:0]];
         end
      end

      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         result.word[k*SYMBOL_BITS +: SYMBOL_BITS] = nxt[k];
      end
      result.is_last = !found;
   end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import nlp_pkg::*;

   typedef struct {
      logic [COUNT_BITS-1:0] count;
      logic [WORD_BITS-1:0]  word;
      bit                    typed;
      result_type            want;
   } vector_row_type;

   localparam int NUM_ROWS   = 22;
   localparam int NUM_PHASES = 13;
   localparam int PHASE_LEN  = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WORD_BITS-1:0]  req_arrangement = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WORD_BITS-1:0]  rsp_next_arrangement;
   logic                  rsp_is_last;
   logic                  csr_wr_en = 1'b0;
   logic [COUNT_BITS-1:0] csr_wr_data = '0;

   result_type            successor_q[$];
   logic [COUNT_BITS-1:0] cur_count = COUNT_RESET;
   int                    mismatches = 0;
   bit                    gappy = 1'b0;
   bit                    calm = 1'b0;
   bit                    hold_request = 1'b0;

   // count, arrangement, typed, expected {word, is_last}
   vector_row_type dir_rows [0:NUM_ROWS-1] = '{
      '{4'd8,  64'h0706050403020100, 1'b1, '{64'h0607050403020100, 1'b0}},
      '{4'd8,  64'h0001020304050607, 1'b1, '{64'h0001020304050607, 1'b1}},
      '{4'd8,  64'h0000000000000000, 1'b1, '{64'h0000000000000000, 1'b1}},
      '{4'd8,  64'hFFFFFFFFFFFFFFFF, 1'b1, '{64'hFFFFFFFFFFFFFFFF, 1'b1}},
      '{4'd8,  64'h00000000000000FF, 1'b1, '{64'h00000000000000FF, 1'b1}},
      '{4'd8,  64'hFF00000000000000, 1'b1, '{64'h00FF000000000000, 1'b0}},
      '{4'd8,  64'h0102010201020102, 1'b0, '{64'h0, 1'b0}},
      '{4'd8,  64'h0403020100050607, 1'b0, '{64'h0, 1'b0}},
      '{4'd8,  64'h5A3C96E10F7B2D88, 1'b0, '{64'h0, 1'b0}},
      '{4'd2,  64'hFFFFFFFFFFFF0100, 1'b1, '{64'h0000000000000001, 1'b0}},
      '{4'd2,  64'hAAAAAAAAAAAA0001, 1'b1, '{64'h0000000000000001, 1'b1}},
      '{4'd2,  64'h0000000000007777, 1'b1, '{64'h0000000000007777, 1'b1}},
      '{4'd15, 64'h0706050403020100, 1'b1, '{64'h0607050403020100, 1'b0}},
      '{4'd15, 64'h8080808080808081, 1'b0, '{64'h0, 1'b0}},
      '{4'd0,  64'h0706050403020100, 1'b1, '{64'h0000000000000000, 1'b1}},
      '{4'd0,  64'hFFFFFFFFFFFFFFFF, 1'b1, '{64'h0000000000000000, 1'b1}},
      '{4'd1,  64'hFFFFFFFFFFFFFF55, 1'b1, '{64'h0000000000000055, 1'b1}},
      '{4'd5,  64'hDEADBE0403020100, 1'b0, '{64'h0, 1'b0}},
      '{4'd5,  64'h1234560001020504, 1'b0, '{64'h0, 1'b0}},
      '{4'd9,  64'h0102030405060708, 1'b0, '{64'h0, 1'b0}},
      '{4'd3,  64'hFF00000000030201, 1'b0, '{64'h0, 1'b0}},
      '{4'd8,  64'h0808070605040302, 1'b0, '{64'h0, 1'b0}}
   };

   logic [COUNT_BITS-1:0] phase_counts [0:NUM_PHASES-1] =
      '{4'd8, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd0, 4'd1, 4'd9, 4'd15, 4'd5, 4'd8};

   next_lexicographic_permutation dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_arrangement      (req_arrangement),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_next_arrangement (rsp_next_arrangement),
      .rsp_is_last          (rsp_is_last),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int active_symbols(input logic [COUNT_BITS-1:0] count);
      return (count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(count);
   endfunction

   function automatic result_type lex_successor(input logic [WORD_BITS-1:0] word,
                                                input logic [COUNT_BITS-1:0] count);
      sym_array_type s;
      symbol_type    t;
      result_type    r;
      int            n, k, m, pivot, ceil_at;
      bit            found;
      s = sym_array_type'(word);
      n = active_symbols(count);
      pivot = 0;
      found = 1'b0;
      for (k = 0; k + 1 < n; k++) begin
         if (s[k] < s[k+1]) begin
            pivot = k;
            found = 1'b1;
         end
      end
      if (found) begin
         ceil_at = pivot + 1;
         for (k = pivot + 2; k < n; k++) begin
            if (s[k] > s[pivot] && s[k] < s[ceil_at]) ceil_at = k;
         end
         t = s[pivot];
         s[pivot] = s[ceil_at];
         s[ceil_at] = t;
         for (k = pivot + 1; k < n; k++) begin
            for (m = k + 1; m < n; m++) begin
               if (s[k] > s[m]) begin
                  t = s[k];
                  s[k] = s[m];
                  s[m] = t;
               end
            end
         end
      end
      r.word = '0;
      for (k = 0; k < n; k++) r.word[k*SYMBOL_BITS +: SYMBOL_BITS] = s[k];
      r.is_last = !found;
      return r;
   endfunction

   // random symbols, often sorted so the last permutation and near-last ones show up
   function automatic logic [WORD_BITS-1:0] shaped_arrangement();
      sym_array_type s;
      symbol_type    t;
      int            k, m, shape, n;
      bit            narrow, swap_it;
      narrow = ($urandom_range(0, 2) == 0);
      shape = $urandom_range(0, 3);
      for (k = 0; k < MAX_SYMBOLS; k++) begin
         s[k] = narrow ? symbol_type'($urandom_range(0, 3)) : symbol_type'($urandom);
      end
      if (shape != 0) begin
         for (k = 0; k < MAX_SYMBOLS; k++) begin
            for (m = k + 1; m < MAX_SYMBOLS; m++) begin
               swap_it = (shape == 3) ? (s[k] > s[m]) : (s[k] < s[m]);
               if (swap_it) begin
                  t = s[k];
                  s[k] = s[m];
                  s[m] = t;
               end
            end
         end
         n = active_symbols(cur_count);
         // one ascent somewhere in an otherwise descending run
         if (shape == 2 && n >= 2) begin
            k = $urandom_range(0, n - 2);
            t = s[k];
            s[k] = s[k+1];
            s[k+1] = t;
         end
      end
      return WORD_BITS'(s);
   endfunction

   task automatic send_arrangement(input logic [WORD_BITS-1:0] word, input bit typed,
                                   input result_type typed_want);
      req_valid <= 1'b1;
      req_arrangement <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      successor_q.push_back(typed ? typed_want : lex_successor(word, cur_count));
   endtask

   task automatic sender_gap();
      if (gappy && !calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (successor_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_BITS-1:0] count);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_count = count;
   endtask

   initial begin : stimulus
      int i, p;
      result_type none;
      none = '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      gappy = 1'b1;
      for (i = 0; i < NUM_ROWS; i++) begin
         if (dir_rows[i].count != cur_count) write_count(dir_rows[i].count);
         send_arrangement(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
         sender_gap();
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         write_count(phase_counts[p]);
         calm = (p == NUM_PHASES - 1);
         // first phase runs back to back so the long receiver hold backs up the input
         gappy = (p != 0) && ($urandom_range(0, 3) != 0);
         for (i = 0; i < PHASE_LEN; i++) begin
            if (p == 0 && i == 20) hold_request = 1'b1;
            send_arrangement(shaped_arrangement(), 1'b0, none);
            sender_gap();
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : result_side
      int         stall_left, hold_left;
      result_type want;
      stall_left = 0;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready) begin
            if (successor_q.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual %h last %b",
                        $time, rsp_next_arrangement, rsp_is_last);
               mismatches++;
            end else begin
               want = successor_q.pop_front();
               if (rsp_next_arrangement !== want.word) begin
                  $display("%0t: next_arrangement expected %h actual %h",
                           $time, want.word, rsp_next_arrangement);
                  mismatches++;
               end
               if (rsp_is_last !== want.is_last) begin
                  $display("%0t: is_last expected %b actual %b",
                           $time, want.is_last, rsp_is_last);
                  mismatches++;
               end
            end
         end
         if (hold_request) begin
            hold_left = 80;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19);
         end
         rsp_ready <= (hold_left == 0 && stall_left == 0);
         @(posedge clock);
      end
   end

endmodule
